FILE: rtl/core/bfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared widths, register indexes and item types for the border fade block.
// ----------------------------------------------------------------------------
package bfw_pkg;

  localparam int IDX_W      = 12;           // row / column index and band width
  localparam int EXT_W      = 13;           // frame extent
  localparam int PIX_W      = 8;
  localparam int QUO_W      = PIX_W + 1;    // quotient never exceeds 256
  localparam int REM_W      = IDX_W + PIX_W; // weight * (256 - p) fits here
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;

  localparam logic [EXT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [EXT_W-1:0] IMAGE_WIDTH_RST  = 13'd640;

  // per-axis result of classification: in a band, and the weight n - d
  typedef struct packed {
    logic             band;
    logic [IDX_W-1:0] weight;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    job_t             row;
    job_t             col;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/bfw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfw_front
// Accepts pixels and classifies row and column against the border bands.
// ----------------------------------------------------------------------------
module bfw_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [bfw_pkg::IDX_W-1:0]  row_index,
  input  wire logic [bfw_pkg::IDX_W-1:0]  col_index,
  input  wire logic [bfw_pkg::PIX_W-1:0]  pixel_in,
  input  wire logic [bfw_pkg::IDX_W-1:0]  fade_width,
  input  wire logic [bfw_pkg::EXT_W-1:0]  image_height,
  input  wire logic [bfw_pkg::EXT_W-1:0]  image_width,
  output logic                            push_vld,
  output bfw_pkg::entry_t                 push_entry,
  input  wire logic                       push_rdy
);
  import bfw_pkg::*;

  logic   vld_r;
  entry_t entry_r;
  entry_t entry_nxt;
  logic   acc;

  function automatic job_t classify(input logic [IDX_W-1:0] x,
                                    input logic [EXT_W-1:0] ext,
                                    input logic [IDX_W-1:0] n);
    job_t             j;
    logic             near;
    logic             far;
    logic [EXT_W-1:0] d;
    begin
      near = (x < n);
      // x >= ext - n, done without going negative
      far  = (({2'b00, x} + {2'b00, n}) >= {1'b0, ext});
      if ({1'b0, x} >= ext) begin
        d = '0;
      end else begin
        d = ext - EXT_W'(1) - {1'b0, x};
      end
      j.band = (n != '0) && (near || far);
      if (near) begin
        j.weight = n - x;
      end else begin
        j.weight = n - d[IDX_W-1:0];
      end
      return j;
    end
  endfunction

  assign busy = vld_r && !push_rdy;
  assign acc  = start && !busy;

  always_comb begin
    entry_nxt.pix = pixel_in;
    entry_nxt.row = classify(row_index, image_height, fade_width);
    entry_nxt.col = classify(col_index, image_width, fade_width);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || push_rdy) begin
      vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      entry_r <= entry_nxt;
    end
  end

  assign push_vld   = vld_r;
  assign push_entry = entry_r;

endmodule

`default_nettype wire

FILE: rtl/core/bfw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfw_queue
// Short queue between classification and the fade datapath.
// ----------------------------------------------------------------------------
module bfw_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_vld,
  input  wire bfw_pkg::entry_t  push_entry,
  output logic                  push_rdy,
  output logic                  pop_vld,
  output bfw_pkg::entry_t       pop_entry
);
  import bfw_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  entry_t               slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [PTR_W:0]       cnt_r;
  logic [PTR_W:0]       cnt_nxt;
  logic                 push;
  logic                 pop;

  // the datapath never stalls, so the head beat leaves every cycle
  assign pop      = (cnt_r != '0);
  assign push_rdy = (cnt_r != (PTR_W+1)'(DEPTH)) || pop;
  assign push     = push_vld && push_rdy;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_vld   = pop;
  assign pop_entry = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

FILE: rtl/core/bfw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfw_back
// Fade datapath: weight multiply, three-step divide stages, saturating add,
// vertical axis first, then horizontal.
// ----------------------------------------------------------------------------
module bfw_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_vld,
  input  wire bfw_pkg::entry_t            in_entry,
  input  wire logic [bfw_pkg::IDX_W-1:0]  fade_width,
  output logic                            out_vld,
  output logic [bfw_pkg::PIX_W-1:0]       out_pix
);
  import bfw_pkg::*;

  localparam int NSTG = 8;

  typedef struct packed {
    logic             vld;
    logic [PIX_W-1:0] pix;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             band;
    job_t             col;
  } pipe_t;

  pipe_t            st_r   [NSTG];
  pipe_t            st_nxt [NSTG];
  logic [REM_W:0]   prod_v;
  logic [REM_W:0]   prod_h;
  logic [PIX_W-1:0] mid_pix;
  logic [PIX_W-1:0] fin_pix;
  logic             out_vld_r;
  logic [PIX_W-1:0] out_pix_r;

  // three restoring-division steps; quotient bits top .. top-2
  function automatic logic [REM_W+QUO_W-1:0] div3(input logic [REM_W-1:0] rem_in,
                                                  input logic [QUO_W-1:0] quo_in,
                                                  input logic [IDX_W-1:0] n,
                                                  input int               top);
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] sh;
    begin
      rem = rem_in;
      quo = quo_in;
      for (int j = 0; j < 3; j++) begin
        sh = REM_W'({{PIX_W{1'b0}}, n} << (top - j));
        if (rem >= sh) begin
          rem = rem - sh;
          quo = quo | (QUO_W'(1) << (top - j));
        end
      end
      return {rem, quo};
    end
  endfunction

  // p + quotient is at most 256
  function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] p,
                                               input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] s;
    begin
      s = {1'b0, p} + q;
      return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
    end
  endfunction

  function automatic logic [REM_W:0] weigh(input logic [IDX_W-1:0] w,
                                           input logic [PIX_W-1:0] p);
    logic [QUO_W-1:0] inv;
    begin
      inv = QUO_W'(256) - {1'b0, p};
      return (REM_W+1)'(w) * (REM_W+1)'(inv);
    end
  endfunction

  assign mid_pix = st_r[3].band ? sat_add(st_r[3].pix, st_r[3].quo) : st_r[3].pix;
  assign fin_pix = st_r[7].band ? sat_add(st_r[7].pix, st_r[7].quo) : st_r[7].pix;
  assign prod_v  = weigh(in_entry.row.weight, in_entry.pix);
  assign prod_h  = weigh(st_r[3].col.weight, mid_pix);

  always_comb begin
    // vertical weight product
    st_nxt[0].vld  = in_vld;
    st_nxt[0].pix  = in_entry.pix;
    st_nxt[0].rem  = prod_v[REM_W-1:0];
    st_nxt[0].quo  = '0;
    st_nxt[0].band = in_entry.row.band;
    st_nxt[0].col  = in_entry.col;
    for (int k = 1; k < 4; k++) begin
      st_nxt[k] = st_r[k-1];
      {st_nxt[k].rem, st_nxt[k].quo} =
        div3(st_r[k-1].rem, st_r[k-1].quo, fade_width, QUO_W - 1 - 3 * (k - 1));
    end
    // vertical result, then horizontal weight product
    st_nxt[4].vld  = st_r[3].vld;
    st_nxt[4].pix  = mid_pix;
    st_nxt[4].rem  = prod_h[REM_W-1:0];
    st_nxt[4].quo  = '0;
    st_nxt[4].band = st_r[3].col.band;
    st_nxt[4].col  = st_r[3].col;
    for (int k = 5; k < NSTG; k++) begin
      st_nxt[k] = st_r[k-1];
      {st_nxt[k].rem, st_nxt[k].quo} =
        div3(st_r[k-1].rem, st_r[k-1].quo, fade_width, QUO_W - 1 - 3 * (k - 5));
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= fin_pix;
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        st_r[k] <= '0;
      end
      out_vld_r <= 1'b0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        st_r[k] <= st_nxt[k];
      end
      out_vld_r <= st_r[NSTG-1].vld;
    end
  end

  assign out_vld = out_vld_r;
  assign out_pix = out_pix_r;

endmodule

`default_nettype wire

FILE: rtl/core/border_fade_to_white.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// border_fade_to_white
// Fades grayscale pixels linearly toward white inside a border band,
// vertical band first, then horizontal band, saturated at 255.
// ----------------------------------------------------------------------------
//  channel   ports                                        handshake
//  input     in_row_index, in_col_index, in_pixel_in      start && !busy
//  result    out_pixel_out                                out_valid strobe
//  config    cfg_index, cfg_data                          cfg_we
//
//  one pixel per clock; a taken beat passes through the classify register,
//  the queue slot, then 8 datapath stages (two multiplies, six three-bit
//  divide stages) and the output register
//  reset is synchronous and empties the pipeline and queue; config resets to
//  fade width 0, 480 rows, 640 columns
//  the datapath never stalls, so busy only rises if the queue were full
// ----------------------------------------------------------------------------
module border_fade_to_white (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [bfw_pkg::IDX_W-1:0]       in_row_index,
  input  wire logic [bfw_pkg::IDX_W-1:0]       in_col_index,
  input  wire logic [bfw_pkg::PIX_W-1:0]       in_pixel_in,
  output logic                                 out_valid,
  output logic [bfw_pkg::PIX_W-1:0]            out_pixel_out,
  input  wire logic                            cfg_we,
  input  wire logic [bfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bfw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfw_pkg::*;

  localparam int LATENCY = 11;

  logic [IDX_W-1:0] fade_width_r;
  logic [EXT_W-1:0] image_height_r;
  logic [EXT_W-1:0] image_width_r;
  logic             push_vld;
  entry_t           push_entry;
  logic             push_rdy;
  logic             pop_vld;
  entry_t           pop_entry;
  logic             in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_width_r   <= '0;
      image_height_r <= IMAGE_HEIGHT_RST;
      image_width_r  <= IMAGE_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_WIDTH:   fade_width_r   <= cfg_data[IDX_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[EXT_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  bfw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .row_index    (in_row_index),
    .col_index    (in_col_index),
    .pixel_in     (in_pixel_in),
    .fade_width   (fade_width_r),
    .image_height (image_height_r),
    .image_width  (image_width_r),
    .push_vld     (push_vld),
    .push_entry   (push_entry),
    .push_rdy     (push_rdy)
  );

  bfw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_vld   (push_vld),
    .push_entry (push_entry),
    .push_rdy   (push_rdy),
    .pop_vld    (pop_vld),
    .pop_entry  (pop_entry)
  );

  bfw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (pop_vld),
    .in_entry   (pop_entry),
    .fade_width (fade_width_r),
    .out_vld    (out_valid),
    .out_pix    (out_pixel_out)
  );

  assign in_acc = start && !busy;

  // every taken beat comes out after the fixed latency
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LATENCY out_valid)
    else $error("result missing after fixed latency");

  // no result without a beat taken the fixed latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, LATENCY))
    else $error("result without matching input beat");

  // the queue drains every cycle, so the front never holds off
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("front stalled on full queue");

endmodule

`default_nettype wire

FILE: test/border_fade_to_white_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// border_fade_to_white_test
// Self-checking bench for the border fade block. A scoreboard predicts every
// faded pixel from its own copy of the band and frame registers and compares
// it with the result strobes in order. A directed set of edge and band
// pixels runs first, then random frames with pixels aimed at the bands, under
// three sender idling profiles.
// ----------------------------------------------------------------------------
module border_fade_to_white_test;
  import bfw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index
  localparam int LATENCY    = 11;
  localparam int IDLE_LIMIT = 500;
  localparam int MAX_GAP    = 40;
  localparam int BLOCKS     = 10;
  localparam int BLOCK_LEN  = 48;
  localparam int SHOW_MAX   = 10;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] faded;
  } fade_entry_t;

  class fade_board;
    int unsigned band   = 0;
    int unsigned height = 480;
    int unsigned width  = 640;
    fade_entry_t faded_q[$];
    int unsigned failures = 0;
    int unsigned checked  = 0;

    function void set_frame(int unsigned n, int unsigned h, int unsigned w);
      band   = n;
      height = h;
      width  = w;
    endfunction

    // one axis: near band wins, far band clamps distance at zero
    function logic [PIX_W-1:0] fade_axis(logic [PIX_W-1:0] p, longint x,
                                         longint extent);
      longint n;
      longint d;
      longint q;
      n = band;
      if (n <= 0) return p;
      if (x < n) begin
        d = x;
      end else if (x >= extent - n) begin
        d = extent - 1 - x;
        if (d < 0) d = 0;
      end else begin
        return p;
      end
      q = longint'(p) + ((n - d) * (256 - longint'(p))) / n;
      if (q > 255) q = 255;
      return PIX_W'(q);
    endfunction

    function void note_pixel(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic [PIX_W-1:0] p);
      fade_entry_t e;
      e.row   = r;
      e.col   = c;
      e.pix   = p;
      e.faded = fade_axis(fade_axis(p, longint'(r), longint'(height)),
                          longint'(c), longint'(width));
      faded_q.push_back(e);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] got);
      fade_entry_t e;
      checked++;
      if (faded_q.size() == 0) begin
        failures++;
        if (failures <= SHOW_MAX)
          $display("result %0d with no pixel outstanding: pixel_out %0d", checked, got);
        return;
      end
      e = faded_q.pop_front();
      if (got !== e.faded) begin
        failures++;
        if (failures <= SHOW_MAX)
          $display("mismatch row %0d col %0d pix %0d (n %0d, %0dx%0d): expected %0d got %0d",
                   e.row, e.col, e.pix, band, height, width, e.faded, got);
      end
    endfunction

    function int pending();
      return faded_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [IDX_W-1:0]      in_row_index = '0;
  logic [IDX_W-1:0]      in_col_index = '0;
  logic [PIX_W-1:0]      in_pixel_in = '0;
  logic                  out_valid;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FADE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fade_board   board;
  int unsigned sender_idle_pct = 13;
  int unsigned pixels_taken = 0;
  int unsigned frames_set = 0;
  int unsigned quiet_cycles = 0;

  border_fade_to_white i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_pixel_out (out_pixel_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // monitor and watchdog: values seen here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        board.note_pixel(in_row_index, in_col_index, in_pixel_in);
        pixels_taken++;
      end
      if (out_valid) board.check_pixel(out_pixel_out);
    end
    if ((start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
                 IDLE_LIMIT, board.pending());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                            input logic [PIX_W-1:0] p);
    int gap;
    gap = 0;
    start        <= 1'b1;
    in_row_index <= r;
    in_col_index <= c;
    in_pixel_in  <= p;
    do @(posedge clk); while (busy);
    // random sender gap, junk on the data lines meanwhile
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) begin
      start        <= 1'b0;
      in_row_index <= IDX_W'($urandom);
      in_col_index <= IDX_W'($urandom);
      in_pixel_in  <= PIX_W'($urandom);
      @(posedge clk);
      gap++;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic program_frame(input int unsigned n, input int unsigned h,
                               input int unsigned w);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FADE_WIDTH;
    cfg_data  <= CFG_DATA_W'(n);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    // unmapped index must leave all registers alone
    cfg_index <= CFG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_frame(n & 32'hFFF, h & 32'h1FFF, w & 32'h1FFF);
    frames_set++;
  endtask

  function automatic int unsigned pick_band();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return $urandom_range(1, 16);
      2:       return $urandom_range(1, 4095);
      3:       return 4095;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic int unsigned pick_extent();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(1, 64);
      2:       return $urandom_range(1, 4096);
      3:       return 4096;
      4:       return $urandom_range(0, 1);
      default: return $urandom_range(4097, 8191);
    endcase
  endfunction

  // aim at the near band, the far band edge, or anywhere
  function automatic logic [IDX_W-1:0] pick_index(int extent);
    int v;
    int n;
    n = int'(board.band);
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, n + 1));
      1:       v = extent - n - 2 + int'($urandom_range(0, n + 4));
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return IDX_W'(v);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: no band, pixels pass through
    send_pixel(12'd0, 12'd0, 8'd0);
    send_pixel(12'd4095, 12'd4095, 8'd255);
    send_pixel(12'd479, 12'd639, 8'd128);
    drain();

    // small frame, band of 4: band edges on both axes, saturation
    program_frame(4, 16, 20);
    send_pixel(12'd0, 12'd10, 8'd0);
    send_pixel(12'd0, 12'd0, 8'd255);
    send_pixel(12'd1, 12'd10, 8'd100);
    send_pixel(12'd3, 12'd10, 8'd77);
    send_pixel(12'd4, 12'd10, 8'd77);
    send_pixel(12'd11, 12'd10, 8'd50);
    send_pixel(12'd12, 12'd10, 8'd50);
    send_pixel(12'd15, 12'd10, 8'd50);
    send_pixel(12'd8, 12'd0, 8'd30);
    send_pixel(12'd8, 12'd15, 8'd200);
    send_pixel(12'd8, 12'd19, 8'd30);
    send_pixel(12'd4095, 12'd5, 8'd9);
    send_pixel(12'd8, 12'd4095, 8'd9);
    send_pixel(12'd2, 12'd18, 8'd60);
    drain();

    // band wider than the frame
    program_frame(10, 6, 3);
    send_pixel(12'd0, 12'd0, 8'd10);
    send_pixel(12'd5, 12'd2, 8'd20);
    send_pixel(12'd9, 12'd9, 8'd123);
    send_pixel(12'd100, 12'd50, 8'd5);
    drain();

    // widest band on an empty frame
    program_frame(4095, 0, 0);
    send_pixel(12'd0, 12'd0, 8'd1);
    send_pixel(12'd4094, 12'd4095, 8'd254);
    drain();

    // narrowest band on the tallest frame, 4096 columns wide
    program_frame(1, 8191, 4096);
    send_pixel(12'd0, 12'd4095, 8'd99);
    send_pixel(12'd4095, 12'd1, 8'd99);
    drain();

    for (int b = 0; b < BLOCKS; b++) begin
      sender_idle_pct = (b < 4) ? 13 : (b < 7) ? 84 : 0;
      program_frame(pick_band(), pick_extent(), pick_extent());
      for (int k = 0; k < BLOCK_LEN; k++)
        send_pixel(pick_index(int'(board.height)), pick_index(int'(board.width)),
                   pick_pixel());
      drain();
    end

    repeat (LATENCY + 5) @(posedge clk);
    $display("%0d pixels over %0d band/frame settings, %0d results checked",
             pixels_taken, frames_set, board.checked);
    $display("%0d failures, %0d pixels still outstanding", board.failures,
             board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
